### sv/spds_pkg.sv
// Shared types and constants for the stepper point drive sequencer.
package spds_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_ACCEPTED    = 3'd1,
        ST_NOT_AT_END  = 3'd2,
        ST_BUSY        = 3'd3,
        ST_END_REACHED = 3'd4,
        ST_STEP_LIMIT  = 3'd5
    } t_status;

    // Sensed point position.
    typedef enum logic [1:0] {
        POS_UNKNOWN = 2'd0,
        POS_LEFT    = 2'd1,
        POS_RIGHT   = 2'd2
    } t_pos;

    // Input item kind carried in tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Configuration register indexes (paddr[3:2]).
    localparam logic [1:0] REG_HALF_STEP_MODE = 2'd0;
    localparam logic [1:0] REG_STEP_LIMIT     = 2'd1;
    localparam logic [1:0] REG_STEP_PERIOD    = 2'd2;

    // Register reset values.
    localparam logic       RST_HALF_STEP_MODE = 1'b1;
    localparam logic [9:0] RST_STEP_LIMIT     = 10'd420;
    localparam logic [7:0] RST_STEP_PERIOD    = 8'd5;

    // Configuration seen by the sequencing core.
    typedef struct packed {
        logic       half_step_mode;
        logic [9:0] step_limit;
        logic [7:0] step_period;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic cmd;
        logic move_right;
        logic force_req;
        logic left_sensor;
        logic right_sensor;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [3:0] coils;
        t_pos       position;
        logic       busy_res;
        t_status    status;
    } t_result;

    // Half-step coil pattern, indexed by phase.
    function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h1;
            3'd2:    pat = 4'h3;
            3'd3:    pat = 4'h2;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'hC;
            default: pat = 4'h8;
        endcase
        return pat;
    endfunction

endpackage

### sv/spds_apb_regs.sv
// APB configuration registers of the stepper point drive sequencer.
module spds_apb_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output spds_pkg::t_cfg   o_cfg
);
    import spds_pkg::*;

    logic       r_half_step_mode;
    logic [9:0] r_step_limit;
    logic [7:0] r_step_period;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_step_mode <= RST_HALF_STEP_MODE;
            r_step_limit     <= RST_STEP_LIMIT;
            r_step_period    <= RST_STEP_PERIOD;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_HALF_STEP_MODE: r_half_step_mode <= pwdata[0];
                REG_STEP_LIMIT:     r_step_limit     <= pwdata[9:0];
                REG_STEP_PERIOD:    r_step_period    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_HALF_STEP_MODE: prdata = {31'd0, r_half_step_mode};
            REG_STEP_LIMIT:     prdata = {22'd0, r_step_limit};
            REG_STEP_PERIOD:    prdata = {24'd0, r_step_period};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{half_step_mode: r_half_step_mode,
                     step_limit:     r_step_limit,
                     step_period:    r_step_period};

endmodule

### sv/spds_core.sv
// Move state and step sequencing logic; one item is processed per advance.
module spds_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  spds_pkg::t_item     i_item,
    input  spds_pkg::t_cfg      i_cfg,
    output spds_pkg::t_result   o_res,
    output logic                o_moving
);
    import spds_pkg::*;

    logic [2:0] r_phase,       n_phase;
    logic [9:0] r_steps_done,  n_steps_done;
    logic [7:0] r_tick_count,  n_tick_count;
    logic       r_moving,      n_moving;
    logic       r_going_right, n_going_right;
    logic [3:0] r_coil_latch,  n_coil_latch;
    t_pos       pos;
    t_status    status;
    logic       at_target;
    logic       start_ok;

    // Position from the end sensors; both or neither active reads as unknown.
    always_comb begin
        if (i_item.left_sensor && !i_item.right_sensor) begin
            pos = POS_LEFT;
        end else if (i_item.right_sensor && !i_item.left_sensor) begin
            pos = POS_RIGHT;
        end else begin
            pos = POS_UNKNOWN;
        end
    end

    assign at_target = (r_going_right && pos == POS_RIGHT) ||
                       (!r_going_right && pos == POS_LEFT);
    assign start_ok  = i_item.force_req ||
                       (i_item.move_right && pos == POS_LEFT) ||
                       (!i_item.move_right && pos == POS_RIGHT);

    // Next state for one item.
    always_comb begin
        n_phase       = r_phase;
        n_steps_done  = r_steps_done;
        n_tick_count  = r_tick_count;
        n_moving      = r_moving;
        n_going_right = r_going_right;
        n_coil_latch  = r_coil_latch;
        status        = ST_NONE;
        if (i_item.cmd == CMD_MOVE) begin
            if (r_moving) begin
                status = ST_BUSY;
            end else if (!start_ok) begin
                status = ST_NOT_AT_END;
            end else begin
                n_moving      = 1'b1;
                n_going_right = i_item.move_right;
                n_phase       = 3'd0;
                n_steps_done  = 10'd0;
                n_tick_count  = 8'd0;
                n_coil_latch  = 4'd0;
                status        = ST_ACCEPTED;
            end
        end else if (r_moving) begin
            if (r_tick_count == 8'd0) begin
                // Step slot: reload the period counter, a zero period acts as one.
                n_tick_count = (i_cfg.step_period == 8'd0) ? 8'd0
                                                           : i_cfg.step_period - 8'd1;
                if (r_steps_done >= i_cfg.step_limit) begin
                    n_moving     = 1'b0;
                    n_coil_latch = 4'd0;
                    status       = ST_STEP_LIMIT;
                end else if (at_target) begin
                    n_moving     = 1'b0;
                    n_coil_latch = 4'd0;
                    status       = ST_END_REACHED;
                end else begin
                    if (i_cfg.half_step_mode || r_phase[0]) begin
                        n_coil_latch = coil_pattern(r_phase);
                    end
                    n_phase      = r_going_right ? r_phase + 3'd1 : r_phase - 3'd1;
                    n_steps_done = r_steps_done + 10'd1;
                end
            end else begin
                n_tick_count = r_tick_count - 8'd1;
            end
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= 3'd0;
            r_steps_done  <= 10'd0;
            r_tick_count  <= 8'd0;
            r_moving      <= 1'b0;
            r_going_right <= 1'b0;
            r_coil_latch  <= 4'd0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_steps_done  <= n_steps_done;
            r_tick_count  <= n_tick_count;
            r_moving      <= n_moving;
            r_going_right <= n_going_right;
            r_coil_latch  <= n_coil_latch;
        end
    end

    assign o_res = '{coils:    n_coil_latch,
                     position: pos,
                     busy_res: n_moving,
                     status:   status};
    assign o_moving = r_moving;

endmodule

### sv/stepper_point_drive_sequencer.sv
// Top level of the stepper point drive sequencer.
// Input items arrive on the s_ stream: s_tuser carries the kind (tick or
// move request), s_tdata the direction, force flag and end sensor levels.
// Every accepted transaction yields exactly one result transaction on the
// m_ stream with the coil drive bits, sensed position, busy flag and status.
// The three registers (half-step mode, step limit, step period) sit on the
// APB port at byte addresses 0, 4 and 8; write them only while idle.
// An item is caught in an input register, processed by the core once the
// output slot is free and written to the output register, which drives
// m_tvalid and m_tdata. One item is taken per clock when m_tready stays
// high; the limit is the state update in the core. When m_tready is low
// the held result stays on the output, the input register fills and
// s_tready drops until room opens.
// Synchronous reset releases the coils, stops any move and restores the
// register defaults (half-step mode on, step limit 420, step period 5).
module stepper_point_drive_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] move_right, [1] force_req, [2] left_sensor,
                                   // [3] right_sensor, [7:4] zero
    input  logic        s_tuser,   // [0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] coils, [5:4] position, [6] busy_res,
                                   // [9:7] status, [15:10] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spds_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    adv;
    t_cfg    cfg;
    t_result core_res;
    logic    core_moving;

    spds_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_res    (core_res),
        .o_moving (core_moving)
    );

    // The core works on the held item once the output slot is free.
    assign adv      = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || adv;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in <= '{cmd:          s_tuser,
                      move_right:   s_tdata[0],
                      force_req:    s_tdata[1],
                      left_sensor:  s_tdata[2],
                      right_sensor: s_tdata[3]};
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'd0, r_out.status, r_out.busy_res, r_out.position, r_out.coils};

`ifndef SYNTH
    // The latest result reflects the current move state.
    a_busy_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == core_moving))
        else $error("result busy flag differs from move state");

    // An accepted move starts with the coils released.
    a_accept_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_ACCEPTED) |->
            (r_out.busy_res && r_out.coils == 4'd0))
        else $error("accepted move not busy or coils driven");

    // A move that ends releases the coils.
    a_end_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_END_REACHED ||
                         r_out.status == ST_STEP_LIMIT)) |->
            (!r_out.busy_res && r_out.coils == 4'd0))
        else $error("ended move left coils driven");

    // A move only stops through a processed item.
    a_stop_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(core_moving) |-> $past(adv))
        else $error("move stopped without an item");
`endif

endmodule
